### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, quiet while reset is asserted
`define ILID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every clock edge, reset included
`define ILID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ilid_pkg.sv
// Types and codes of the indexed list insert/delete unit
package ilid_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [2:0] ACT_READ      = 3'd0;
  localparam logic [2:0] ACT_INS_FRONT = 3'd1;
  localparam logic [2:0] ACT_INS_BACK  = 3'd2;
  localparam logic [2:0] ACT_INS_POS   = 3'd3;
  localparam logic [2:0] ACT_DEL_POS   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_CELL = 2'd1,
    RD_NEG  = 2'd2
  } rd_kind_e;

endpackage

### rtl/core/ilid_cell.sv
// One storage cell of the list: holds one entry, shifts with its neighbors
module ilid_cell #(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic                clk_i,
  input  ilid_pkg::cell_op_e  op_i,
  input  logic [IDX_W-1:0]    pos_i,
  input  ilid_pkg::word_t     value_i,
  input  ilid_pkg::word_t     left_i,
  input  ilid_pkg::word_t     right_i,
  output ilid_pkg::word_t     data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  ilid_pkg::word_t data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (op_i)
      ilid_pkg::CELL_INS: begin
        if (MyIdx > pos_i) begin
          data_d = left_i;
        end else if (MyIdx == pos_i) begin
          data_d = value_i;
        end
      end
      ilid_pkg::CELL_DEL: begin
        if (MyIdx >= pos_i) begin
          data_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### rtl/core/ilid_read_tree.sv
// Two-level read selection over the row of cells, registered after the first level
module ilid_read_tree #(
  parameter int CAPACITY = 256,
  parameter int IDX_W    = 8
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [IDX_W-1:0]   pos_i,
  input  ilid_pkg::word_t    cell_i [CAPACITY],
  output ilid_pkg::word_t    data_o
);

  localparam int LoW  = IDX_W / 2;
  localparam int Grp  = 2 ** LoW;
  localparam int NGrp = 2 ** (IDX_W - LoW);

  ilid_pkg::word_t term   [NGrp][Grp];
  ilid_pkg::word_t grp_d  [NGrp];
  ilid_pkg::word_t grp_q  [NGrp];
  logic [IDX_W-1:0] pos_q;
  logic [IDX_W-1:0] hi_sel;

  for (genvar g = 0; g < NGrp; g++) begin : g_grp
    for (genvar k = 0; k < Grp; k++) begin : g_mem
      if (g * Grp + k < CAPACITY) begin : g_live
        assign term[g][k] = (pos_i == IDX_W'(g * Grp + k)) ? cell_i[g * Grp + k] : '0;
      end else begin : g_pad
        assign term[g][k] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < Grp; k++) begin
        grp_d[g] = grp_d[g] | term[g][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_q <= pos_i;
      grp_q <= grp_d;
    end
  end

  assign hi_sel = pos_q >> LoW;

  always_comb begin
    data_o = '0;
    for (int g = 0; g < NGrp; g++) begin
      if (hi_sel == IDX_W'(g)) begin
        data_o = data_o | grp_q[g];
      end
    end
  end

endmodule

### rtl/core/indexed_list_insert_delete_unit.sv
// Indexed list insert/delete unit: top level
//
// Holds an ordered list of up to CAPACITY signed 32-bit values in a row of cells. A transaction
// reads, inserts (front, back, at a position) or deletes (at a position) and returns a status,
// the value read and the new count. At the accepting edge every cell at or beyond the position
// shifts by one place for an insert or delete, all cells in parallel, and the first level of the
// read selection loads; then the second read level feeds the output register. A new transaction
// is taken once the previous result has moved into the output register, so the unit never holds
// more than one pending transaction. count_o is $clog2(CAPACITY+1) bits
// wide (9 at the default). Entries not yet written read as undefined but are never returned.
module indexed_list_insert_delete_unit #(
  parameter int CAPACITY = 256,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          action_i,
  input  logic [7:0]          position_i,
  input  logic signed [31:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  read_value_o,
  output logic [1:0]          status_o,
  output logic [CNT_W-1:0]    count_o
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW    = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

  logic                 accept;
  logic                 move;
  logic                 pend_q;
  logic                 out_valid_q;
  logic [CNT_W-1:0]     cnt_d, cnt_q;
  logic [PW-1:0]        pos_ext, cnt_ext;
  logic [IDX_W-1:0]     pos_idx, cnt_idx;
  logic                 full;

  ilid_pkg::cell_op_e   op_dec, cell_op;
  logic [IDX_W-1:0]     op_pos;
  logic [1:0]           st_dec, st_pend_q;
  ilid_pkg::rd_kind_e   rdk_dec, rdk_q;

  ilid_pkg::word_t      cell_data [CAPACITY];
  ilid_pkg::word_t      tree_data;
  ilid_pkg::word_t      rd_val;

  logic signed [31:0]   read_value_q;
  logic [1:0]           status_q;
  logic [CNT_W-1:0]     count_q;

  assign accept  = in_valid_i & in_ready_o;
  assign move    = pend_q & (~out_valid_q | out_ready_i);
  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(cnt_q);
  assign pos_idx = pos_ext[IDX_W-1:0];
  assign cnt_idx = cnt_ext[IDX_W-1:0];
  assign full    = (cnt_q >= Cap);

  always_comb begin
    op_dec  = ilid_pkg::CELL_HOLD;
    op_pos  = pos_idx;
    st_dec  = ilid_pkg::ST_DONE;
    rdk_dec = ilid_pkg::RD_ZERO;
    cnt_d   = cnt_q;
    case (action_i)
      ilid_pkg::ACT_READ: begin
        if (pos_ext < cnt_ext) begin
          rdk_dec = ilid_pkg::RD_CELL;
        end else begin
          rdk_dec = ilid_pkg::RD_NEG;
          st_dec  = ilid_pkg::ST_RANGE;
        end
      end
      ilid_pkg::ACT_INS_FRONT: begin
        if (full) begin
          st_dec = ilid_pkg::ST_FULL;
        end else begin
          op_dec = ilid_pkg::CELL_INS;
          op_pos = '0;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      ilid_pkg::ACT_INS_BACK: begin
        if (full) begin
          st_dec = ilid_pkg::ST_FULL;
        end else begin
          op_dec = ilid_pkg::CELL_INS;
          op_pos = cnt_idx;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      ilid_pkg::ACT_INS_POS: begin
        if (pos_ext > cnt_ext) begin
          st_dec = ilid_pkg::ST_RANGE;
        end else if (full) begin
          st_dec = ilid_pkg::ST_FULL;
        end else begin
          op_dec = ilid_pkg::CELL_INS;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      ilid_pkg::ACT_DEL_POS: begin
        if (pos_ext >= cnt_ext) begin
          st_dec = ilid_pkg::ST_RANGE;
        end else begin
          op_dec = ilid_pkg::CELL_DEL;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cell_op = accept ? op_dec : ilid_pkg::CELL_HOLD;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ilid_pkg::word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    ilid_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (op_pos),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i])
    );
  end

  ilid_read_tree #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_read_tree (
    .clk_i  (clk_i),
    .load_i (accept),
    .pos_i  (pos_idx),
    .cell_i (cell_data),
    .data_o (tree_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
        cnt_q  <= cnt_d;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_pend_q <= st_dec;
      rdk_q     <= rdk_dec;
    end
  end

  always_comb begin
    case (rdk_q)
      ilid_pkg::RD_CELL: rd_val = tree_data;
      ilid_pkg::RD_NEG:  rd_val = '1;
      default:           rd_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      read_value_q <= rd_val;
      status_q     <= st_pend_q;
      count_q      <= cnt_q;
    end
  end

  assign in_ready_o   = ~pend_q;
  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign count_o      = count_q;

endmodule

### rtl/core/ilid_checker.sv
// Port-level assertion checker for the indexed list insert/delete unit, with its bind
`include "assert_macros.svh"

module ilid_checker #(
  parameter int CAPACITY = 256,
  parameter int CNT_W    = 9
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic signed [31:0]  read_value_o,
  input logic [1:0]          status_o,
  input logic [CNT_W-1:0]    count_o
);

  localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

  logic                stall_w;
  logic                take_w;
  logic                full_w;
  logic [CNT_W+33:0]   res_w;

  assign stall_w = out_valid_o && !out_ready_i;
  assign take_w  = in_valid_i && in_ready_o;
  assign full_w  = out_valid_o && (status_o == ilid_pkg::ST_FULL);
  assign res_w   = {read_value_o, status_o, count_o};

  `ILID_ASSERT(a_out_hold, clk_i, rst_ni, stall_w |=> out_valid_o && $stable(res_w), "result moved")
  `ILID_ASSERT(a_one_at_a_time, clk_i, rst_ni, take_w |=> !in_ready_o, "transaction taken early")
  `ILID_ASSERT(a_count_bound, clk_i, rst_ni, out_valid_o |-> count_o <= Cap, "count beyond capacity")
  `ILID_ASSERT(a_full_count, clk_i, rst_ni, full_w |-> count_o == Cap, "full status with room left")
  `ILID_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind indexed_list_insert_delete_unit ilid_checker #(
  .CAPACITY (CAPACITY),
  .CNT_W    (CNT_W)
) u_ilid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_value_o (read_value_o),
  .status_o     (status_o),
  .count_o      (count_o)
);
